/* rtl/core/gtg_pkg.sv */
// gtg_pkg: shared types and constants of the go-to-goal proportional controller
// item payloads, register indexes, datapath widths and the CORDIC arctangent table
// depends on nothing; compiled first
package gtg_pkg;

	localparam int POS_W   = 16;
	localparam int ERR_W   = 17;
	localparam int HEAD_W  = 16;
	localparam int GAIN_W  = 12;
	localparam int DIST_W  = 17;
	localparam int ANG_W   = 15;
	localparam int HERR_W  = 17;
	localparam int CMD_W   = 20;
	localparam int GUARD_W = 8;
	localparam int XW      = 27;
	localparam int ZW      = 33;
	localparam int ATAN_W  = 30;
	localparam int PROD_W  = 56;
	localparam int LPROD_W = GAIN_W + DIST_W;
	localparam int APROD_W = GAIN_W + 1 + HERR_W;
	localparam int ATAN_N  = 24;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_addr_t;

	localparam cfg_addr_t REG_GOAL_X       = 3'd0;
	localparam cfg_addr_t REG_GOAL_Y       = 3'd1;
	localparam cfg_addr_t REG_LINEAR_GAIN  = 3'd2;
	localparam cfg_addr_t REG_ANGULAR_GAIN = 3'd3;
	localparam cfg_addr_t REG_DEADBAND     = 3'd4;

	localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST  = 12'd461;
	localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RST = 12'd1280;
	localparam logic [15:0]       DEADBAND_RST     = 16'd1;

	localparam logic [ATAN_W-1:0] INV_GAIN_Q30 = 30'd652032874;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;
	localparam logic signed [ZW-1:0] ANG_RND = 33'sd131072;
	localparam logic [PROD_W-1:0] DIST_RND = 56'd137438953472;

	localparam logic signed [CMD_W:0] CMD_MAX = 21'sd524287;
	localparam logic signed [CMD_W:0] CMD_MIN = -21'sd524288;

	// atan(2^-i) in unsigned Q0.30, rounded to nearest
	localparam logic [ATAN_W-1:0] ATAN_Q30 [ATAN_N] = '{
		30'd843314857, 30'd497837830, 30'd263043837, 30'd133525159,
		30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
		30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
		30'd262144,    30'd131072,    30'd65536,     30'd32768,
		30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128
	};

	typedef struct packed {
		logic signed [POS_W-1:0]  pose_x;
		logic signed [POS_W-1:0]  pose_y;
		logic signed [HEAD_W-1:0] pose_heading;
	} pose_t;

	typedef struct packed {
		logic signed [CMD_W-1:0] linear_cmd;
		logic signed [CMD_W-1:0] angular_cmd;
	} cmd_t;

endpackage

/* rtl/core/gtg_pose_if.sv */
// gtg_pose_if: valid/ready channel that carries one pose item
// depends on gtg_pkg
interface gtg_pose_if;
	import gtg_pkg::*;

	logic  valid;
	logic  ready;
	pose_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/gtg_cmd_if.sv */
// gtg_cmd_if: valid/ready channel that carries one velocity command item
// depends on gtg_pkg
interface gtg_cmd_if;
	import gtg_pkg::*;

	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/go_to_goal_p_controller_core.sv */
// go_to_goal_p_controller_core: pose in, proportional velocity command out
// throughput one item per cycle while the skid stage is empty
// every CORDIC micro-rotation has its own register stage
// output register plus a one-item skid stage; a held command fills the skid, then pose.ready drops
// arst_n clears all valid bits and loads the register reset values
// depends on gtg_pkg, gtg_pose_if, gtg_cmd_if
module go_to_goal_p_controller_core #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  gtg_pkg::cfg_addr_t                  cfg_index,
	input  logic [gtg_pkg::CFG_DATA_W-1:0]      cfg_data,
	gtg_pose_if.sink                            pose,
	gtg_cmd_if.source                           cmd
);
	import gtg_pkg::*;

	logic signed [POS_W-1:0] goal_x_q;
	logic signed [POS_W-1:0] goal_y_q;
	logic [GAIN_W-1:0]       lin_gain_q;
	logic [GAIN_W-1:0]       ang_gain_q;
	logic [15:0]             deadband_q;

	logic adv;

	// s1: position error
	logic                     v_s1;
	logic signed [ERR_W-1:0]  ex_s1, ey_s1;
	logic signed [HEAD_W-1:0] head_s1;

	// s2: quadrant pre-rotation
	logic                     v_s2, zero_s2;
	logic signed [XW-1:0]     x_s2, y_s2;
	logic signed [ZW-1:0]     z_s2;
	logic signed [HEAD_W-1:0] head_s2;

	// s3: micro-rotations
	logic                     v_s3    [CORDIC_STAGES];
	logic                     zero_s3 [CORDIC_STAGES];
	logic signed [XW-1:0]     x_s3    [CORDIC_STAGES];
	logic signed [XW-1:0]     y_s3    [CORDIC_STAGES];
	logic signed [ZW-1:0]     z_s3    [CORDIC_STAGES];
	logic signed [HEAD_W-1:0] head_s3 [CORDIC_STAGES];

	logic                     v_in    [CORDIC_STAGES];
	logic                     zero_in [CORDIC_STAGES];
	logic signed [XW-1:0]     x_in    [CORDIC_STAGES];
	logic signed [XW-1:0]     y_in    [CORDIC_STAGES];
	logic signed [ZW-1:0]     z_in    [CORDIC_STAGES];
	logic signed [HEAD_W-1:0] head_in [CORDIC_STAGES];

	// s4: gain correction and angle rounding
	logic                     v_s4;
	logic [PROD_W-1:0]        prod_s4;
	logic signed [ANG_W-1:0]  ang_s4;
	logic signed [HEAD_W-1:0] head_s4;

	// s5: distance, heading error, deadband
	logic                     v_s5;
	logic [DIST_W-1:0]        dist_s5;
	logic signed [HERR_W-1:0] herr_s5;

	// s6: gain products
	logic                      v_s6;
	logic [LPROD_W-1:0]        lprod_s6;
	logic signed [APROD_W-1:0] aprod_s6;

	logic out_valid_q, skid_valid_q;
	cmd_t out_q, skid_q, result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q   <= '0;
			goal_y_q   <= '0;
			lin_gain_q <= LINEAR_GAIN_RST;
			ang_gain_q <= ANGULAR_GAIN_RST;
			deadband_q <= DEADBAND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GOAL_X:       goal_x_q   <= cfg_data[POS_W-1:0];
				REG_GOAL_Y:       goal_y_q   <= cfg_data[POS_W-1:0];
				REG_LINEAR_GAIN:  lin_gain_q <= cfg_data[GAIN_W-1:0];
				REG_ANGULAR_GAIN: ang_gain_q <= cfg_data[GAIN_W-1:0];
				REG_DEADBAND:     deadband_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign adv = !skid_valid_q;
	assign pose.ready = adv;

	always_comb begin
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			if (i == 0) begin
				v_in[i]    = v_s2;
				zero_in[i] = zero_s2;
				x_in[i]    = x_s2;
				y_in[i]    = y_s2;
				z_in[i]    = z_s2;
				head_in[i] = head_s2;
			end else begin
				v_in[i]    = v_s3[i-1];
				zero_in[i] = zero_s3[i-1];
				x_in[i]    = x_s3[i-1];
				y_in[i]    = y_s3[i-1];
				z_in[i]    = z_s3[i-1];
				head_in[i] = head_s3[i-1];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int i = 0; i < CORDIC_STAGES; i++) v_s3[i] <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pose.valid;
			v_s2 <= v_s1;
			for (int i = 0; i < CORDIC_STAGES; i++) v_s3[i] <= v_in[i];
			v_s4 <= v_s3[CORDIC_STAGES-1];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// s1 and s2
	logic signed [XW-1:0] xe, ye;
	assign xe = {{(XW-ERR_W-GUARD_W){ex_s1[ERR_W-1]}}, ex_s1, {GUARD_W{1'b0}}};
	assign ye = {{(XW-ERR_W-GUARD_W){ey_s1[ERR_W-1]}}, ey_s1, {GUARD_W{1'b0}}};

	always_ff @(posedge clk) begin
		if (adv) begin
			ex_s1   <= {goal_x_q[POS_W-1], goal_x_q} - {pose.data.pose_x[POS_W-1], pose.data.pose_x};
			ey_s1   <= {goal_y_q[POS_W-1], goal_y_q} - {pose.data.pose_y[POS_W-1], pose.data.pose_y};
			head_s1 <= pose.data.pose_heading;

			zero_s2 <= (ex_s1 == '0) && (ey_s1 == '0);
			head_s2 <= head_s1;
			if (xe[XW-1]) begin
				if (!ye[XW-1]) begin
					x_s2 <= ye;
					y_s2 <= -xe;
					z_s2 <= HALF_PI_Q30;
				end else begin
					x_s2 <= -ye;
					y_s2 <= xe;
					z_s2 <= -HALF_PI_Q30;
				end
			end else begin
				x_s2 <= xe;
				y_s2 <= ye;
				z_s2 <= '0;
			end
		end
	end

	// s3: one micro-rotation per stage
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				zero_s3[i] <= zero_in[i];
				head_s3[i] <= head_in[i];
				if (!y_in[i][XW-1]) begin
					x_s3[i] <= x_in[i] + (y_in[i] >>> i);
					y_s3[i] <= y_in[i] - (x_in[i] >>> i);
					z_s3[i] <= z_in[i] + $signed({{(ZW-ATAN_W){1'b0}}, ATAN_Q30[i]});
				end else begin
					x_s3[i] <= x_in[i] - (y_in[i] >>> i);
					y_s3[i] <= y_in[i] + (x_in[i] >>> i);
					z_s3[i] <= z_in[i] - $signed({{(ZW-ATAN_W){1'b0}}, ATAN_Q30[i]});
				end
			end
		end
	end

	// s4 to s6
	logic signed [ZW-1:0]     zsum;
	logic [PROD_W-1:0]        dsum;
	logic [DIST_W-1:0]        dist_val;
	logic signed [HERR_W-1:0] herr;
	logic                     in_band;

	assign zsum     = z_s3[CORDIC_STAGES-1] + ANG_RND;
	assign dsum     = prod_s4 + DIST_RND;
	assign dist_val = dsum[PROD_W-2:PROD_W-1-DIST_W];
	assign herr     = {{(HERR_W-ANG_W){ang_s4[ANG_W-1]}}, ang_s4}
		- {{(HERR_W-HEAD_W){head_s4[HEAD_W-1]}}, head_s4};
	assign in_band  = dist_val < {{(DIST_W-16){1'b0}}, deadband_q};

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s4 <= PROD_W'(x_s3[CORDIC_STAGES-1][XW-2:0]) * PROD_W'(INV_GAIN_Q30);
			ang_s4  <= zero_s3[CORDIC_STAGES-1] ? '0 : zsum[ZW-1:ZW-ANG_W];
			head_s4 <= head_s3[CORDIC_STAGES-1];

			dist_s5 <= in_band ? '0 : dist_val;
			herr_s5 <= in_band ? '0 : herr;

			lprod_s6 <= LPROD_W'(lin_gain_q) * LPROD_W'(dist_s5);
			aprod_s6 <= APROD_W'($signed({1'b0, ang_gain_q}))
				* APROD_W'(herr_s5);
		end
	end

	// rounding and saturation
	logic [LPROD_W:0]          lsum;
	logic [LPROD_W-8:0]        lsh;
	logic signed [APROD_W:0]   asum;
	logic signed [CMD_W:0]     ash;

	assign lsum = {1'b0, lprod_s6} + (LPROD_W+1)'(128);
	assign lsh  = lsum[LPROD_W:8];
	assign asum = {aprod_s6[APROD_W-1], aprod_s6} + (APROD_W+1)'(512);
	assign ash  = asum[APROD_W:APROD_W-CMD_W];

	always_comb begin
		if (lsh > (LPROD_W-7)'(CMD_MAX)) result.linear_cmd = CMD_MAX[CMD_W-1:0];
		else result.linear_cmd = lsh[CMD_W-1:0];
		if (ash > CMD_MAX) result.angular_cmd = CMD_MAX[CMD_W-1:0];
		else if (ash < CMD_MIN) result.angular_cmd = CMD_MIN[CMD_W-1:0];
		else result.angular_cmd = ash[CMD_W-1:0];
	end

	// output register and skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || cmd.ready) begin
			out_valid_q  <= skid_valid_q || v_s6;
			skid_valid_q <= 1'b0;
		end else if (adv && v_s6) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || cmd.ready) begin
			out_q <= skid_valid_q ? skid_q : result;
		end else if (adv && v_s6) begin
			skid_q <= result;
		end
	end

	assign cmd.valid = out_valid_q;
	assign cmd.data  = out_q;

endmodule

/* dv/go_to_goal_p_controller_core_tb.sv */
`timescale 1ns / 100ps
// go_to_goal_p_controller_core_tb: self-checking bench for the go-to-goal command core
// drives poses and register writes, predicts each command with its own CORDIC, checks in order
// depends on gtg_pkg, gtg_pose_if, gtg_cmd_if and go_to_goal_p_controller_core
module go_to_goal_p_controller_core_tb;
	import gtg_pkg::*;

	localparam int STAGES      = 16;
	localparam int LATENCY     = STAGES + 6;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 94;
	localparam int MAX_REPORTS = 10;

	localparam longint INV_K_Q30       = 64'sd652032874;
	localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
	localparam longint CMD_HI          = 64'sd524287;
	localparam longint CMD_LO          = -64'sd524288;
	localparam longint ARCTAN_Q30 [24] = '{
		843314857, 497837830, 263043837, 133525159,
		67021687,  33543516,  16775851,  8388437,
		4194283,   2097149,   1048576,   524288,
		262144,    131072,    65536,     32768,
		16384,     8192,      4096,      2048,
		1024,      512,       256,       128
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_addr_t cfg_index = REG_GOAL_X;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	gtg_pose_if pose();
	gtg_cmd_if cmd();

	go_to_goal_p_controller_core #(
		.CORDIC_STAGES(STAGES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pose(pose),
		.cmd(cmd)
	);

	logic signed [POS_W-1:0] goal_x_q = '0;
	logic signed [POS_W-1:0] goal_y_q = '0;
	logic [GAIN_W-1:0] lin_gain_q = 12'd461;
	logic [GAIN_W-1:0] ang_gain_q = 12'd1280;
	logic [15:0] deadband_q = 16'd1;

	cmd_t expected_cmds[$];
	int errors = 0;
	int cycle_count = 0;
	int rx_hold = 0;
	bit rx_random = 1'b1;
	bit tx_random = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic longint sat_cmd(longint v);
		if (v > CMD_HI)
			return CMD_HI;
		if (v < CMD_LO)
			return CMD_LO;
		return v;
	endfunction

	function automatic cmd_t predict_command(pose_t p);
		longint ex, ey, x, y, z, t, dx, dy, distance, ang, herr, lin, angv;
		longint unsigned prod;
		cmd_t c;
		ex = longint'(goal_x_q) - longint'(p.pose_x);
		ey = longint'(goal_y_q) - longint'(p.pose_y);
		if (ex == 0 && ey == 0) begin
			distance = 0;
			ang = 0;
		end else begin
			x = ex * 256;
			y = ey * 256;
			z = 0;
			// left half plane: quarter turn first
			if (x < 0) begin
				if (y >= 0) begin
					t = y;
					y = -x;
					x = t;
					z = QUARTER_TURN_Q30;
				end else begin
					t = -y;
					y = x;
					x = t;
					z = -QUARTER_TURN_Q30;
				end
			end
			for (int i = 0; i < STAGES && i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x = x + dx;
					y = y - dy;
					z = z + ARCTAN_Q30[i];
				end else begin
					x = x - dx;
					y = y + dy;
					z = z - ARCTAN_Q30[i];
				end
			end
			prod = longint'(x) * INV_K_Q30 + (64'd1 << 37);
			distance = longint'(prod >> 38);
			ang = (z + (64'sd1 <<< 17)) >>> 18;
		end
		herr = ang - longint'(p.pose_heading);
		if (distance < longint'(deadband_q)) begin
			distance = 0;
			herr = 0;
		end
		lin = sat_cmd((longint'(lin_gain_q) * distance + 128) >>> 8);
		angv = sat_cmd((longint'(ang_gain_q) * herr + 512) >>> 10);
		c.linear_cmd = lin[CMD_W-1:0];
		c.angular_cmd = angv[CMD_W-1:0];
		return c;
	endfunction

	function automatic pose_t pose_of(logic [15:0] x, logic [15:0] y, logic [15:0] h);
		pose_t p;
		p.pose_x = x;
		p.pose_y = y;
		p.pose_heading = h;
		return p;
	endfunction

	function automatic pose_t random_pose();
		pose_t p;
		int r, dx, dy;
		r = $urandom_range(0, 99);
		dx = $urandom_range(0, 64) - 32;
		dy = $urandom_range(0, 64) - 32;
		p.pose_x = 16'($urandom);
		p.pose_y = 16'($urandom);
		p.pose_heading = 16'($urandom);
		if (r >= 60 && r < 75) begin
			p.pose_x = goal_x_q + dx[15:0];
			p.pose_y = goal_y_q + dy[15:0];
		end else if (r >= 75 && r < 85) begin
			p.pose_x = goal_x_q;
		end else if (r >= 85 && r < 95) begin
			p.pose_y = goal_y_q;
		end else if (r >= 95) begin
			p.pose_x = goal_x_q;
			p.pose_y = goal_y_q;
		end
		return p;
	endfunction

	task automatic write_reg(input cfg_addr_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GOAL_X: goal_x_q = val;
			REG_GOAL_Y: goal_y_q = val;
			REG_LINEAR_GAIN: lin_gain_q = val[GAIN_W-1:0];
			REG_ANGULAR_GAIN: ang_gain_q = val[GAIN_W-1:0];
			REG_DEADBAND: deadband_q = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] gx, input logic [15:0] gy,
			input logic [11:0] lg, input logic [11:0] ag, input logic [15:0] db);
		write_reg(REG_GOAL_X, gx);
		write_reg(REG_GOAL_Y, gy);
		write_reg(REG_LINEAR_GAIN, {4'($urandom), lg});
		write_reg(REG_ANGULAR_GAIN, {4'($urandom), ag});
		write_reg(REG_DEADBAND, db);
	endtask

	task automatic send_pose(input pose_t p);
		int gap;
		logic taken;
		gap = tx_random ? pick_gap() : 0;
		if (gap > 0) begin
			pose.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pose.valid <= 1'b1;
		pose.data <= p;
		do begin
			@(negedge clk);
			taken = pose.ready;
			@(posedge clk);
		end while (taken !== 1'b1);
		expected_cmds.push_back(predict_command(p));
	endtask

	task automatic wait_idle();
		pose.valid <= 1'b0;
		while (expected_cmds.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input longint want, input longint got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch %s: expected %0d actual %0d", what, want, got);
	endtask

	task automatic check_command(input cmd_t got);
		cmd_t want;
		if (expected_cmds.size() == 0) begin
			report_mismatch("unexpected item linear_cmd", 0, got.linear_cmd);
			return;
		end
		want = expected_cmds.pop_front();
		if (got.linear_cmd !== want.linear_cmd)
			report_mismatch("linear_cmd", want.linear_cmd, got.linear_cmd);
		if (got.angular_cmd !== want.angular_cmd)
			report_mismatch("angular_cmd", want.angular_cmd, got.angular_cmd);
	endtask

	// command sink: random stalls, free running, or a counted hold-off
	initial begin : cmd_sink
		int stall_left, run_left;
		stall_left = 0;
		run_left = 0;
		cmd.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				cmd.ready <= 1'b0;
				rx_hold--;
			end else if (!rx_random) begin
				cmd.ready <= 1'b1;
			end else if (stall_left > 0) begin
				cmd.ready <= 1'b0;
				stall_left--;
			end else if (run_left > 0) begin
				cmd.ready <= 1'b1;
				run_left--;
			end else begin
				run_left = $urandom_range(0, 12);
				stall_left = pick_gap();
				cmd.ready <= 1'b1;
			end
		end
	end

	initial begin : cmd_monitor
		forever begin
			@(negedge clk);
			if (arst_n && cmd.valid === 1'b1 && cmd.ready === 1'b1)
				check_command(cmd.data);
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("go_to_goal_p_controller_core_tb NOT OK");
		$finish;
	end

	task automatic test_reset_config();
		send_pose(pose_of(16'sd0, 16'sd0, 16'sd0));
		send_pose(pose_of(16'sd0, 16'sd0, 16'sd32767));
		send_pose(pose_of(-16'sd32768, -16'sd32768, -16'sd32768));
		send_pose(pose_of(16'sd32767, 16'sd32767, 16'sd32767));
		send_pose(pose_of(16'sd32767, -16'sd32768, 16'sd0));
		send_pose(pose_of(16'sd1024, 16'sd0, -16'sd12868));
		send_pose(pose_of(-16'sd1, 16'sd0, 16'sd0));
		wait_idle();
	endtask

	task automatic test_extreme_config();
		set_config(16'sd32767, -16'sd32768, 12'd4095, 12'd4095, 16'd0);
		send_pose(pose_of(-16'sd32768, 16'sd32767, -16'sd32768));
		send_pose(pose_of(16'sd32767, -16'sd32768, 16'sd32767));
		send_pose(pose_of(-16'sd32768, -16'sd32768, 16'sd0));
		wait_idle();
		set_config(-16'sd32768, 16'sd32767, 12'd0, 12'd0, 16'd1);
		send_pose(pose_of(16'sd32767, -16'sd32768, 16'sd32767));
		send_pose(pose_of(16'sd0, 16'sd0, -16'sd32768));
		wait_idle();
	endtask

	task automatic test_deadband();
		set_config(16'sd0, 16'sd0, 12'd461, 12'd1280, 16'd1024);
		send_pose(pose_of(-16'sd1024, 16'sd0, 16'sd100));
		send_pose(pose_of(-16'sd1023, 16'sd0, 16'sd100));
		send_pose(pose_of(-16'sd1025, 16'sd0, 16'sd100));
		wait_idle();
		write_reg(REG_DEADBAND, 16'd0);
		send_pose(pose_of(16'sd0, 16'sd0, 16'sd4096));
		wait_idle();
		set_config(16'sd32767, 16'sd32767, 12'd461, 12'd1280, 16'd65535);
		send_pose(pose_of(16'sd0, 16'sd0, 16'sd0));
		send_pose(pose_of(-16'sd32768, -16'sd32768, 16'sd2000));
		wait_idle();
	endtask

	task automatic test_unknown_index();
		for (int k = int'(REG_DEADBAND) + 1; k < (1 << CFG_IDX_W); k++)
			write_reg(cfg_addr_t'(k), 16'($urandom));
		send_pose(pose_of(16'sd5000, -16'sd7000, 16'sd300));
		send_pose(pose_of(-16'sd12000, 16'sd9000, -16'sd300));
		wait_idle();
	endtask

	task automatic test_backpressure();
		tx_random = 1'b0;
		rx_hold = 300;
		for (int n = 0; n < 60; n++)
			send_pose(random_pose());
		wait_idle();
		tx_random = 1'b1;
	endtask

	task automatic randomize_config();
		logic [11:0] lg, ag;
		logic [15:0] db;
		int r;
		r = $urandom_range(0, 9);
		lg = (r == 0) ? 12'd0 : (r == 1) ? 12'd4095 : 12'($urandom);
		r = $urandom_range(0, 9);
		ag = (r == 0) ? 12'd0 : (r == 1) ? 12'd4095 : 12'($urandom);
		r = $urandom_range(0, 19);
		db = (r < 2) ? 16'd0 : (r == 2) ? 16'd65535 : 16'($urandom_range(0, 2048));
		set_config(16'($urandom), 16'($urandom), lg, ag, db);
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 5; ph++) begin
			rx_random = (ph != 1 && ph != 3);
			tx_random = (ph != 1 && ph != 2);
			randomize_config();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 2)
					wait_idle();
				send_pose(random_pose());
			end
			wait_idle();
		end
		rx_random = 1'b1;
		tx_random = 1'b1;
	endtask

	initial begin
		pose.valid <= 1'b0;
		pose.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_extreme_config();
		test_deadband();
		test_unknown_index();
		test_backpressure();
		test_random();
		wait_idle();
		if (errors == 0)
			$display("go_to_goal_p_controller_core_tb OK");
		else
			$display("go_to_goal_p_controller_core_tb NOT OK");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/gtg_pkg.sv
rtl/core/gtg_pose_if.sv
rtl/core/gtg_cmd_if.sv
rtl/core/go_to_goal_p_controller_core.sv
dv/go_to_goal_p_controller_core_tb.sv
